/* hdl/assert_macros.svh */
// Assertion macros shared by the replay filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/mrf_pkg.sv */
// Types, constants, microcode program and helper functions of the replay filter.
package mrf_pkg;

  localparam int HASH_W  = 64;
  localparam int STAMP_W = 32;
  localparam int DIGITS  = 10;
  localparam int NAME_MAX = 12;
  localparam int NAME_W  = 8 * NAME_MAX;

  localparam int DEF_CRITICAL_DEPTH = 32;
  localparam int DEF_TRAIL_DEPTH    = 32;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  localparam logic [1:0] KIND_SOS     = 2'd0;
  localparam logic [1:0] KIND_CHECKIN = 2'd1;
  localparam logic [1:0] KIND_TRAIL   = 2'd2;

  localparam logic [23:0] TEXT_SOS     = "SOS";
  localparam logic [55:0] TEXT_CHECKIN = "CheckIn";
  localparam logic [95:0] TEXT_TRAIL   = "TrailMessage";

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COLON1,
    ST_NAME,
    ST_COLON2,
    ST_WAIT,
    ST_DIGIT,
    ST_SCAN,
    ST_DRAIN,
    ST_HOLD,
    ST_RECORD
  } step_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_NOP,
    OP_COLON,
    OP_NAME,
    OP_DIGIT,
    OP_SCAN,
    OP_RECORD
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_FINISH,
    C_NAME_END,
    C_BCD_DONE,
    C_DIGIT_END,
    C_SCAN_END,
    C_OUT_FREE
  } cond_t;

  // One control word: datapath operation, jump condition and jump target.
  // When the condition is false the sequencer repeats the current step.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
  } ctrl_t;

  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    unique case (s)
      ST_IDLE:   c = '{op: OP_IDLE,   cond: C_FINISH,    jump: ST_COLON1};
      ST_COLON1: c = '{op: OP_COLON,  cond: C_ALWAYS,    jump: ST_NAME};
      ST_NAME:   c = '{op: OP_NAME,   cond: C_NAME_END,  jump: ST_COLON2};
      ST_COLON2: c = '{op: OP_COLON,  cond: C_ALWAYS,    jump: ST_WAIT};
      ST_WAIT:   c = '{op: OP_NOP,    cond: C_BCD_DONE,  jump: ST_DIGIT};
      ST_DIGIT:  c = '{op: OP_DIGIT,  cond: C_DIGIT_END, jump: ST_SCAN};
      ST_SCAN:   c = '{op: OP_SCAN,   cond: C_SCAN_END,  jump: ST_DRAIN};
      ST_DRAIN:  c = '{op: OP_NOP,    cond: C_ALWAYS,    jump: ST_HOLD};
      ST_HOLD:   c = '{op: OP_NOP,    cond: C_OUT_FREE,  jump: ST_RECORD};
      ST_RECORD: c = '{op: OP_RECORD, cond: C_ALWAYS,    jump: ST_IDLE};
      default:   c = '{op: OP_NOP,    cond: C_ALWAYS,    jump: ST_IDLE};
    endcase
    return c;
  endfunction

  // One djb2 step with the character sign-extended.
  function automatic logic [HASH_W-1:0] fold(input logic [HASH_W-1:0] h,
                                             input logic [7:0] c);
    logic [HASH_W-1:0] ext;
    ext = {{(HASH_W-8){c[7]}}, c};
    return (h << 5) + h + ext;
  endfunction

  function automatic logic [3:0] name_last(input logic [1:0] kind);
    logic [3:0] last;
    unique case (kind)
      KIND_SOS:     last = 4'd2;
      KIND_CHECKIN: last = 4'd6;
      default:      last = 4'd11;
    endcase
    return last;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] kind,
                                           input logic [3:0] pos);
    logic [NAME_W-1:0] text;
    unique case (kind)
      KIND_SOS:     text = NAME_W'(TEXT_SOS) << (NAME_W - 24);
      KIND_CHECKIN: text = NAME_W'(TEXT_CHECKIN) << (NAME_W - 56);
      default:      text = TEXT_TRAIL;
    endcase
    return text[NAME_W - 8 - 8 * int'(pos) +: 8];
  endfunction

endpackage

/* hdl/mrf_ifs.sv */
// Valid/ready channel interfaces for message items and verdicts.
interface mrf_in_if import mrf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               action;
  logic [7:0]         sender_byte;
  logic [1:0]         msg_kind;
  logic [STAMP_W-1:0] stamp;

  modport source (output valid, action, sender_byte, msg_kind, stamp, input ready);
  modport sink (input valid, action, sender_byte, msg_kind, stamp, output ready);
endinterface

interface mrf_out_if import mrf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_replay;
  logic [HASH_W-1:0] msg_hash;

  modport source (output valid, is_replay, msg_hash, input ready);
  modport sink (input valid, is_replay, msg_hash, output ready);
endinterface

/* hdl/mrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module mrf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/mrf_bcd.sv */
// Binary to decimal converter, one double-dabble shift per cycle.
module mrf_bcd import mrf_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [STAMP_W-1:0]     value,
  output logic                   done,
  output logic [DIGITS-1:0][3:0] digits
);
  localparam int CNT_W = $clog2(STAMP_W + 1);

  logic [STAMP_W-1:0]     bin;
  logic [DIGITS-1:0][3:0] bcd;
  logic [DIGITS*4-1:0]    bcd_adj;
  logic [CNT_W-1:0]       count;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= CNT_W'(STAMP_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= value;
      bcd <= '0;
    end else if (count != '0) begin
      bcd <= {bcd_adj[DIGITS*4-2:0], bin[STAMP_W-1]};
      bin <= {bin[STAMP_W-2:0], 1'b0};
    end
  end

  assign done   = (count == '0);
  assign digits = bcd;
endmodule

/* hdl/message_replay_filter.sv */
// Top level of the replay filter: hash sequencer, decimal converter and seen-hash rings.
//
// The msg channel carries one transaction per identifier byte (action 0) or a
// finish transaction (action 1) with the message kind and timestamp. Each
// finish produces exactly one transaction on the verdict channel: the final
// 64-bit hash and whether it was already in the critical ring (SOS, CheckIn)
// or the trail ring (all other kinds). A miss records the hash over the
// oldest ring entry; a hit records nothing.
// A byte transaction is folded in the cycle it is taken, so bytes stream at
// one per cycle between finishes. A finish runs a microcoded program: suffix
// characters, a decimal conversion of the stamp that overlaps them, up to ten
// digit folds and a scan of the selected ring at one entry per cycle. Once
// the finish is taken, no new transaction is taken on msg until the verdict
// is issued. The verdict is held in an output register, so the next message's
// bytes are taken while a verdict waits; a stalled verdict only holds back
// the verdict of the next finish.
// Reset empties both rings (never-written entries read as zero), clears the
// ring pointers and returns the running hash to 5381; no clearing pass runs.
`include "assert_macros.svh"

module message_replay_filter import mrf_pkg::*; #(
  parameter int CRITICAL_DEPTH = DEF_CRITICAL_DEPTH,
  parameter int TRAIL_DEPTH    = DEF_TRAIL_DEPTH
) (
  input logic       clk,
  input logic       rst,
  mrf_in_if.sink    msg,
  mrf_out_if.source verdict
);
  localparam int CRIT_AW  = (CRITICAL_DEPTH > 1) ? $clog2(CRITICAL_DEPTH) : 1;
  localparam int TRAIL_AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int SCAN_W   = (CRIT_AW > TRAIL_AW) ? CRIT_AW : TRAIL_AW;

  step_t step, step_next;
  ctrl_t ctrl;
  logic  cond_true;
  logic  accept;

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] hash_fold;
  logic [7:0]        fold_char;
  logic [1:0]        kind;
  logic              crit_sel;

  logic [3:0]        name_pos;
  logic [3:0]        digit_idx;
  logic [3:0]        digit_val;
  logic              started;
  logic [SCAN_W-1:0] scan_idx;
  logic [SCAN_W-1:0] scan_last;
  logic              cmp_pend;
  logic              cmp_vld;
  logic              hit;
  logic [HASH_W-1:0] entry;

  logic [CRIT_AW-1:0]  crit_next;
  logic                crit_full;
  logic                crit_we;
  logic [HASH_W-1:0]   crit_rdata;
  logic [TRAIL_AW-1:0] trail_next;
  logic                trail_full;
  logic                trail_we;
  logic [HASH_W-1:0]   trail_rdata;

  logic                   bcd_start;
  logic                   bcd_done;
  logic [DIGITS-1:0][3:0] bcd_digits;

  logic              out_valid;
  logic              out_replay;
  logic [HASH_W-1:0] out_hash;

  mrf_bcd u_bcd (
    .clk    (clk),
    .rst    (rst),
    .start  (bcd_start),
    .value  (msg.stamp),
    .done   (bcd_done),
    .digits (bcd_digits)
  );

  mrf_ram #(.WIDTH(HASH_W), .DEPTH(CRITICAL_DEPTH)) u_crit_ram (
    .clk   (clk),
    .we    (crit_we),
    .waddr (crit_next),
    .wdata (running_hash),
    .raddr (scan_idx[CRIT_AW-1:0]),
    .rdata (crit_rdata)
  );

  mrf_ram #(.WIDTH(HASH_W), .DEPTH(TRAIL_DEPTH)) u_trail_ram (
    .clk   (clk),
    .we    (trail_we),
    .waddr (trail_next),
    .wdata (running_hash),
    .raddr (scan_idx[TRAIL_AW-1:0]),
    .rdata (trail_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

  always_comb begin
    ctrl      = ucode(step);
    accept    = msg.valid && msg.ready;
    scan_last = crit_sel ? SCAN_W'(CRITICAL_DEPTH - 1) : SCAN_W'(TRAIL_DEPTH - 1);
    unique case (ctrl.cond)
      C_ALWAYS:    cond_true = 1'b1;
      C_FINISH:    cond_true = accept && msg.action;
      C_NAME_END:  cond_true = (name_pos == name_last(kind));
      C_BCD_DONE:  cond_true = bcd_done;
      C_DIGIT_END: cond_true = (digit_idx == '0);
      C_SCAN_END:  cond_true = (scan_idx == scan_last);
      C_OUT_FREE:  cond_true = !out_valid || verdict.ready;
      default:     cond_true = 1'b0;
    endcase
    step_next = cond_true ? ctrl.jump : step;
  end

  assign msg.ready = (ctrl.op == OP_IDLE);
  assign bcd_start = accept && msg.action;
  assign digit_val = bcd_digits[digit_idx];

  always_comb begin
    unique case (ctrl.op)
      OP_COLON: fold_char = CHAR_COLON;
      OP_NAME:  fold_char = name_char(kind, name_pos);
      OP_DIGIT: fold_char = CHAR_ZERO + 8'(digit_val);
      default:  fold_char = msg.sender_byte;
    endcase
  end

  assign hash_fold = fold(running_hash, fold_char);
  assign entry     = cmp_vld ? (crit_sel ? crit_rdata : trail_rdata) : '0;
  assign crit_we   = (ctrl.op == OP_RECORD) && crit_sel && !hit;
  assign trail_we  = (ctrl.op == OP_RECORD) && !crit_sel && !hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
      started      <= 1'b0;
      hit          <= 1'b0;
      cmp_pend     <= 1'b0;
    end else begin
      cmp_pend <= (ctrl.op == OP_SCAN);
      if (cmp_pend && (entry == running_hash)) begin
        hit <= 1'b1;
      end
      unique case (ctrl.op)
        OP_IDLE: begin
          if (accept && !msg.action) begin
            running_hash <= hash_fold;
          end
          if (accept && msg.action) begin
            hit <= 1'b0;
          end
        end
        OP_COLON: begin
          running_hash <= hash_fold;
          started      <= 1'b0;
        end
        OP_NAME: begin
          running_hash <= hash_fold;
        end
        OP_DIGIT: begin
          if (started || (digit_val != '0) || (digit_idx == '0)) begin
            running_hash <= hash_fold;
            started      <= 1'b1;
          end
        end
        OP_RECORD: begin
          running_hash <= HASH_SEED;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && msg.action) begin
      kind     <= msg.msg_kind;
      crit_sel <= (msg.msg_kind == KIND_SOS) || (msg.msg_kind == KIND_CHECKIN);
    end
    cmp_vld <= crit_sel ? (crit_full || (scan_idx < SCAN_W'(crit_next)))
                        : (trail_full || (scan_idx < SCAN_W'(trail_next)));
    unique case (ctrl.op)
      OP_COLON: begin
        name_pos  <= '0;
        digit_idx <= 4'(DIGITS - 1);
        scan_idx  <= '0;
      end
      OP_NAME: begin
        name_pos <= name_pos + 1'b1;
      end
      OP_DIGIT: begin
        if (digit_idx != '0) begin
          digit_idx <= digit_idx - 1'b1;
        end
      end
      OP_SCAN: begin
        if (scan_idx != scan_last) begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crit_next  <= '0;
      crit_full  <= 1'b0;
      trail_next <= '0;
      trail_full <= 1'b0;
    end else begin
      if (crit_we) begin
        if (crit_next == CRIT_AW'(CRITICAL_DEPTH - 1)) begin
          crit_next <= '0;
          crit_full <= 1'b1;
        end else begin
          crit_next <= crit_next + 1'b1;
        end
      end
      if (trail_we) begin
        if (trail_next == TRAIL_AW'(TRAIL_DEPTH - 1)) begin
          trail_next <= '0;
          trail_full <= 1'b1;
        end else begin
          trail_next <= trail_next + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == OP_RECORD) begin
      out_valid <= 1'b1;
    end else if (verdict.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_RECORD) begin
      out_replay <= hit;
      out_hash   <= running_hash;
    end
  end

  assign verdict.valid     = out_valid;
  assign verdict.is_replay = out_replay;
  assign verdict.msg_hash  = out_hash;

  `MRF_ASSERT_NEXT(a_ptr_still, ctrl.op != OP_RECORD,
                   $stable(crit_next) && $stable(trail_next),
                   "ring pointer moved outside a record step")
  `MRF_ASSERT_SAME(a_hit_no_write, (ctrl.op == OP_RECORD) && hit,
                   !crit_we && !trail_we, "ring written on a replay")
  `MRF_ASSERT_SAME(a_one_ring, crit_we, !trail_we,
                   "both rings written in one transaction")
  `MRF_ASSERT_SAME(a_digits_ready, ctrl.op == OP_DIGIT, bcd_done,
                   "digit fold before conversion finished")
  `MRF_ASSERT_NEXT(a_hash_reseed, ctrl.op == OP_RECORD, running_hash == HASH_SEED,
                   "running hash not reseeded after finish")
endmodule
